FILE: sv/ffpa_pkg.sv
// Shared types and codes for the first-fit page run allocator.
`timescale 1ns / 1ps
package ffpa_pkg;

    localparam logic [1:0] OUT_DONE       = 2'd0;
    localparam logic [1:0] OUT_ALLOC_FAIL = 2'd1;
    localparam logic [1:0] OUT_FREE_REJ   = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] request_bytes;
        logic [31:0] release_address;
    } in_item_t;

    typedef struct packed {
        logic [31:0] granted_address;
        logic [1:0]  outcome;
        logic [12:0] blocks_free;
        logic [12:0] blocks_used;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic load;
        logic scan_step;
        logic fill_step;
        logic rd_index;
        logic free_check;
        logic unfill_step;
        logic set_fail;
        logic res_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic bad;
        logic is_free;
        logic found;
        logic exhausted;
        logic fill_last;
        logic blk_used;
        logic unfill_last;
    } sts_t;

endpackage

FILE: sv/ffpa_dp.sv
// Datapath: block maps, run bound memories, scan counters and result register.
`timescale 1ns / 1ps
module ffpa_dp #(
    parameter int NUM_BLOCKS  = 4096,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [31:0]        cfg_wr_data,
    input  ffpa_pkg::in_item_t item_in,
    input  ffpa_pkg::cmd_t     cmd,
    output ffpa_pkg::sts_t     sts,
    output ffpa_pkg::out_item_t result
);
    import ffpa_pkg::*;

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int LOG_B = $clog2(BLOCK_BYTES);

    logic             used_mem [NUM_BLOCKS];
    logic [IDX_W-1:0] rf_mem   [NUM_BLOCKS];
    logic [IDX_W-1:0] rl_mem   [NUM_BLOCKS];

    logic             used_rd;
    logic [IDX_W-1:0] rf_rd;
    logic [IDX_W-1:0] rl_rd;

    logic [31:0]      base_reg;
    logic             mode_reg;
    logic             bad_reg;
    logic [CNT_W-1:0] need_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] ctr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic [IDX_W-1:0] first_reg;
    logic [IDX_W-1:0] last_reg;
    logic [CNT_W-1:0] used_total_reg;
    logic [31:0]      addr_reg;
    logic [1:0]       code_reg;
    out_item_t        result_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] ctr_idx;
    logic [32:0]      need_sum;
    logic [32:0]      need_full;
    logic [32:0]      off_full;
    logic [31:0]      blk_full;
    logic             alloc_bad;
    logic             free_bad;
    logic [CNT_W-1:0] count_inc;
    logic             scan_found;
    logic [IDX_W-1:0] scan_first;
    logic             issue_ok;
    logic [IDX_W+LOG_B-1:0] grant_off;
    logic [CNT_W-1:0] run_len;
    logic [CNT_W-1:0] free_cnt;

    assign ctr_idx  = ctr_reg[IDX_W-1:0];
    assign rd_addr  = cmd.rd_index ? idx_reg : ctr_idx;

    assign need_sum  = {1'b0, item_in.request_bytes} + 33'(BLOCK_BYTES - 1);
    assign need_full = need_sum >> LOG_B;
    assign alloc_bad = (item_in.request_bytes == 32'd0) || (need_full > 33'(NUM_BLOCKS));
    assign off_full  = {1'b0, item_in.release_address} - {1'b0, base_reg};
    assign blk_full  = off_full[31:0] >> LOG_B;
    assign free_bad  = (item_in.release_address == 32'd0) || off_full[32]
                       || (blk_full >= 32'(NUM_BLOCKS));

    assign count_inc  = count_reg + 1'b1;
    assign scan_found = pend_reg && !used_rd && (count_inc == need_reg);
    assign scan_first = pend_idx_reg - count_reg[IDX_W-1:0];
    assign issue_ok   = ctr_reg < CNT_W'(NUM_BLOCKS);
    assign grant_off  = {first_reg, {LOG_B{1'b0}}};
    assign run_len    = CNT_W'(last_reg) - CNT_W'(first_reg) + 1'b1;
    assign free_cnt   = CNT_W'(NUM_BLOCKS) - used_total_reg;

    always_comb begin
        sts.clear_last  = (ctr_idx == IDX_W'(NUM_BLOCKS - 1));
        sts.bad         = bad_reg;
        sts.is_free     = (mode_reg == MODE_FREE);
        sts.found       = scan_found;
        sts.exhausted   = pend_reg && !scan_found
                          && (pend_idx_reg == IDX_W'(NUM_BLOCKS - 1));
        sts.fill_last   = (ctr_idx == last_reg);
        sts.blk_used    = used_rd;
        sts.unfill_last = (ctr_idx == last_reg);
    end

    // memories: one write port each, registered read
    always_ff @(posedge aclk) begin
        used_rd <= used_mem[rd_addr];
        rf_rd   <= rf_mem[rd_addr];
        rl_rd   <= rl_mem[rd_addr];
        if (cmd.clear_step || cmd.unfill_step) begin
            used_mem[ctr_idx] <= 1'b0;
        end else if (cmd.fill_step) begin
            used_mem[ctr_idx] <= 1'b1;
        end
        if (cmd.fill_step) begin
            rf_mem[ctr_idx] <= first_reg;
            rl_mem[ctr_idx] <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg       <= 32'h0050_0000;
            ctr_reg        <= '0;
            used_total_reg <= '0;
            pend_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            if (cmd.clear_step) begin
                ctr_reg <= ctr_reg + 1'b1;
            end
            if (cmd.load) begin
                mode_reg  <= item_in.mode;
                bad_reg   <= (item_in.mode == MODE_FREE) ? free_bad : alloc_bad;
                need_reg  <= CNT_W'(need_full);
                idx_reg   <= IDX_W'(blk_full);
                ctr_reg   <= '0;
                count_reg <= '0;
                pend_reg  <= 1'b0;
            end
            if (cmd.scan_step) begin
                pend_reg     <= issue_ok;
                pend_idx_reg <= ctr_idx;
                if (issue_ok) begin
                    ctr_reg <= ctr_reg + 1'b1;
                end
                if (pend_reg) begin
                    count_reg <= used_rd ? '0 : count_inc;
                end
                if (scan_found) begin
                    first_reg <= scan_first;
                    last_reg  <= pend_idx_reg;
                    ctr_reg   <= CNT_W'(scan_first);
                end
            end
            if (cmd.fill_step) begin
                ctr_reg <= ctr_reg + 1'b1;
                if (ctr_idx == last_reg) begin
                    used_total_reg <= used_total_reg + need_reg;
                    addr_reg       <= base_reg + 32'(grant_off);
                    code_reg       <= OUT_DONE;
                end
            end
            if (cmd.free_check) begin
                first_reg <= rf_rd;
                last_reg  <= rl_rd;
                ctr_reg   <= CNT_W'(rf_rd);
            end
            if (cmd.unfill_step) begin
                ctr_reg <= ctr_reg + 1'b1;
                if (ctr_idx == last_reg) begin
                    used_total_reg <= used_total_reg - run_len;
                    addr_reg       <= '0;
                    code_reg       <= OUT_DONE;
                end
            end
            if (cmd.set_fail) begin
                addr_reg <= '0;
                code_reg <= (mode_reg == MODE_FREE) ? OUT_FREE_REJ : OUT_ALLOC_FAIL;
            end
            if (cmd.res_load) begin
                result_reg.granted_address <= addr_reg;
                result_reg.outcome         <= code_reg;
                result_reg.blocks_free     <= 13'(free_cnt);
                result_reg.blocks_used     <= 13'(used_total_reg);
            end
        end
    end

    assign result = result_reg;

endmodule

FILE: sv/ffpa_ctrl.sv
// Controller: sequences clearing, first-fit scan, run fill/release and result hand-off.
`timescale 1ns / 1ps
module ffpa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  ffpa_pkg::sts_t sts,
    output ffpa_pkg::cmd_t cmd
);
    import ffpa_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_CHECK, ST_SCAN, ST_FILL,
        ST_FREE_RD, ST_FREE_CHK, ST_UNFILL, ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.bad) begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_RESULT;
                end else if (sts.is_free) begin
                    state_next = ST_FREE_RD;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.found) begin
                    state_next = ST_FILL;
                end else if (sts.exhausted) begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_RESULT;
                end
            end
            ST_FILL: begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last) state_next = ST_RESULT;
            end
            ST_FREE_RD: begin
                cmd.rd_index = 1'b1;
                state_next   = ST_FREE_CHK;
            end
            ST_FREE_CHK: begin
                if (!sts.blk_used) begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_RESULT;
                end else begin
                    cmd.free_check = 1'b1;
                    state_next     = ST_UNFILL;
                end
            end
            ST_UNFILL: begin
                cmd.unfill_step = 1'b1;
                if (sts.unfill_last) state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.res_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;

endmodule

FILE: sv/first_fit_page_run_allocator.sv
// Sequence per item: an allocation scans the used map from block 0 and fills the first run
// that fits; a free reads the run bounds of its block and releases the run; rejects skip both.
// Throughput: one item at a time; the next item is taken in the cycle after the result is
// loaded, later while a previous result waits; the used-map scan reads one block per cycle.
// Reset: synchronous, active low; a clearing pass over every block then empties the used
// map, and no item is taken until it ends.
`timescale 1ns / 1ps
module first_fit_page_run_allocator #(
    parameter int NUM_BLOCKS  = 4096,
    parameter int BLOCK_BYTES = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  ffpa_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ffpa_pkg::out_item_t m_data
);
    import ffpa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ffpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ffpa_dp #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_in     (s_data),
        .cmd         (cmd),
        .sts         (sts),
        .result      (m_data)
    );

`ifndef SYNTHESIS
    a_fail_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.outcome != OUT_DONE) |-> m_data.granted_address == 32'd0)
        else $error("failed item carries an address");
    a_counts_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 13'(m_data.blocks_free + m_data.blocks_used) == 13'(NUM_BLOCKS))
        else $error("free and used counts disagree");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken while busy");
    a_outcome_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.outcome != 2'd3)
        else $error("unknown outcome code");
`endif

endmodule

FILE: dv/ffpa_checker.sv
// Checker for the page run allocator: tracks the used map, predicts results and compares.
`timescale 1ns / 1ps
module ffpa_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [31:0]         cfg_wr_data,
    input  logic                s_valid,
    input  logic                s_ready,
    input  ffpa_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  ffpa_pkg::out_item_t m_data,
    output int                  outstanding,
    output int                  errors
);
    import ffpa_pkg::*;

    localparam int NBLK      = 4096;
    localparam int BLK_BYTES = 4096;

    logic        used_map [NBLK];
    logic [11:0] run_lo   [NBLK];
    logic [11:0] run_hi   [NBLK];
    int          used_cnt;
    logic [31:0] region_base;
    out_item_t   expected_q[$];

    initial begin
        outstanding = 0;
        errors      = 0;
    end

    function automatic out_item_t make_result(logic [31:0] addr, logic [1:0] oc);
        out_item_t r;
        r.granted_address = addr;
        r.outcome         = oc;
        r.blocks_free     = 13'(NBLK - used_cnt);
        r.blocks_used     = 13'(used_cnt);
        return r;
    endfunction

    // first fit over the used map
    function automatic out_item_t alloc_run(logic [31:0] bytes);
        longint unsigned need;
        int run;
        int first;
        run = 0;
        if (bytes == 32'd0) return make_result(32'd0, OUT_ALLOC_FAIL);
        need = ({32'd0, bytes} + BLK_BYTES - 1) / BLK_BYTES;
        if (need > NBLK) return make_result(32'd0, OUT_ALLOC_FAIL);
        for (int i = 0; i < NBLK; i++) begin
            if (used_map[i]) begin
                run = 0;
            end else begin
                run++;
                if (run == need) begin
                    first = i + 1 - run;
                    for (int k = first; k <= i; k++) begin
                        used_map[k] = 1'b1;
                        run_lo[k]   = 12'(first);
                        run_hi[k]   = 12'(i);
                    end
                    used_cnt += run;
                    return make_result(region_base + 32'(first * BLK_BYTES), OUT_DONE);
                end
            end
        end
        return make_result(32'd0, OUT_ALLOC_FAIL);
    endfunction

    function automatic out_item_t free_run(logic [31:0] addr);
        logic [31:0] idx;
        if (addr == 32'd0 || addr < region_base) return make_result(32'd0, OUT_FREE_REJ);
        idx = (addr - region_base) / BLK_BYTES;
        if (idx >= NBLK || !used_map[idx]) return make_result(32'd0, OUT_FREE_REJ);
        for (int k = run_lo[idx]; k <= run_hi[idx]; k++) begin
            if (used_map[k]) begin
                used_map[k] = 1'b0;
                if (used_cnt > 0) used_cnt--;
            end
        end
        return make_result(32'd0, OUT_DONE);
    endfunction

    task automatic report_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
        $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
        errors++;
    endtask

    always @(posedge aclk) begin
        out_item_t e;
        if (!aresetn) begin
            for (int k = 0; k < NBLK; k++) begin
                used_map[k] = 1'b0;
                run_lo[k]   = '0;
                run_hi[k]   = '0;
            end
            used_cnt    = 0;
            region_base = 32'h0050_0000;
            expected_q.delete();
        end else begin
            if (cfg_wr_en) region_base = cfg_wr_data;
            if (s_valid && s_ready) begin
                if (s_data.mode == MODE_ALLOC) expected_q.push_back(alloc_run(s_data.request_bytes));
                else expected_q.push_back(free_run(s_data.release_address));
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result item with nothing expected", $time);
                    errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (m_data.granted_address !== e.granted_address)
                        report_mismatch("granted_address", e.granted_address,
                                        m_data.granted_address);
                    if (m_data.outcome !== e.outcome)
                        report_mismatch("outcome", 32'(e.outcome), 32'(m_data.outcome));
                    if (m_data.blocks_free !== e.blocks_free)
                        report_mismatch("blocks_free", 32'(e.blocks_free), 32'(m_data.blocks_free));
                    if (m_data.blocks_used !== e.blocks_used)
                        report_mismatch("blocks_used", 32'(e.blocks_used), 32'(m_data.blocks_used));
                end
            end
        end
        outstanding = expected_q.size();
    end
endmodule

FILE: dv/tb_top.sv
// Testbench top for the page run allocator: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top;
    import ffpa_pkg::*;

    localparam int BLK_BYTES = 4096;
    localparam int NBLK      = 4096;
    localparam int WD_LIMIT  = 60000;

    typedef struct {
        int blk;
        int len;
    } run_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    int          outstanding;
    int          errors;

    logic [31:0] cur_base;
    bit          no_idle;
    run_t        live_runs[$];
    int          sent_len_q[$];
    int          quiet_cycles;

    first_fit_page_run_allocator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    ffpa_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .outstanding(outstanding), .errors(errors)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= no_idle || ($urandom_range(99) >= 38);
    end

    // remember granted runs so later frees can hit them
    always @(posedge aclk) begin
        int len;
        if (aresetn && s_valid && s_ready)
            sent_len_q.push_back(s_data.mode == MODE_ALLOC ?
                                 int'(({32'd0, s_data.request_bytes} + BLK_BYTES - 1) / BLK_BYTES)
                                 : 0);
        if (aresetn && m_valid && m_ready && sent_len_q.size() > 0) begin
            len = sent_len_q.pop_front();
            if (len > 0 && m_data.outcome == OUT_DONE)
                live_runs.push_back('{int'((m_data.granted_address - cur_base) / BLK_BYTES), len});
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("[first_fit_page_run_allocator] ERROR");
            $finish;
        end
    end

    task automatic send(logic mode, logic [31:0] bytes, logic [31:0] addr);
        while (!no_idle && $urandom_range(99) < 38) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid              <= 1'b1;
        s_data.mode          <= mode;
        s_data.request_bytes <= bytes;
        s_data.release_address <= addr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_base(logic [31:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cur_base    = v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] addr_in_run(run_t r);
        return cur_base + 32'(r.blk * BLK_BYTES) + 32'($urandom_range(r.len * BLK_BYTES - 1));
    endfunction

    task automatic free_all();
        run_t r;
        while (live_runs.size() > 0) begin
            r = live_runs.pop_front();
            send(MODE_FREE, $urandom, addr_in_run(r));
        end
        wait_idle();
    endtask

    task automatic random_item();
        int r;
        int len;
        int pick;
        r = $urandom_range(99);
        if (live_runs.size() > 30) r = 60;
        if (r < 45) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
            send(MODE_ALLOC, 32'(len * BLK_BYTES - $urandom_range(BLK_BYTES - 1)), $urandom);
        end else if (r < 80 && live_runs.size() > 0) begin
            pick = $urandom_range(live_runs.size() - 1);
            send(MODE_FREE, $urandom, addr_in_run(live_runs[pick]));
            live_runs.delete(pick);
        end else begin
            case ($urandom_range(5))
                0: send(MODE_ALLOC, $urandom, $urandom);
                1: send(MODE_ALLOC, 32'd0, $urandom);
                2: send(MODE_FREE, $urandom, $urandom);
                3: send(MODE_FREE, $urandom, 32'd0);
                4: send(MODE_FREE, $urandom, cur_base - 32'($urandom_range(1, 64)));
                default: send(MODE_FREE, $urandom,
                              cur_base + 32'($urandom_range(NBLK - 1) * BLK_BYTES));
            endcase
        end
    endtask

    task automatic random_phase(int n);
        repeat (n) random_item();
        wait_idle();
    endtask

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_valid     <= 1'b0;
        s_data      <= '0;
        cur_base    = 32'h0050_0000;
        no_idle     = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: fresh map, default base
        send(MODE_ALLOC, 32'd1, 32'hFFFF_FFFF);
        send(MODE_ALLOC, 32'd4096, 32'd0);
        send(MODE_ALLOC, 32'd4097, $urandom);
        send(MODE_ALLOC, 32'd0, $urandom);
        send(MODE_ALLOC, 32'hFFFF_FFFF, $urandom);
        send(MODE_ALLOC, 32'd4096 * 32'd4096, $urandom);      // no room
        send(MODE_ALLOC, 32'd4096 * 32'd4096 + 32'd1, $urandom);
        send(MODE_FREE, 32'hFFFF_FFFF, 32'd0);
        send(MODE_FREE, $urandom, cur_base - 32'd1);
        send(MODE_FREE, $urandom, cur_base + 32'd4096 * 32'd4096);
        send(MODE_FREE, $urandom, cur_base + 32'd4096 * 32'd4095);
        send(MODE_FREE, $urandom, 32'hFFFF_FFFF);
        wait_idle();
        free_all();
        send(MODE_ALLOC, 32'd4096 * 32'd4096, $urandom);      // whole region
        send(MODE_ALLOC, 32'd1, $urandom);
        send(MODE_FREE, $urandom, cur_base + 32'd4096 * 32'd4096 - 32'd1);
        send(MODE_FREE, $urandom, cur_base);                   // already released
        wait_idle();
        live_runs.delete();

        random_phase(250);
        free_all();

        write_base(32'h0150_0000);
        no_idle = 1'b1;
        random_phase(200);
        no_idle = 1'b0;
        random_phase(150);
        free_all();

        write_base(32'h0000_0000);
        random_phase(150);

        // high bases: the granted address wraps, runs past the top stay held
        write_base(32'hFFFF_F000);
        random_phase(25);
        write_base(32'hFFFF_FFFF);
        random_phase(25);

        write_base(32'h0050_0000);
        free_all();
        random_phase(250);
        free_all();

        wait_idle();
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("[first_fit_page_run_allocator] OK");
        else $display("[first_fit_page_run_allocator] ERROR");
        $finish;
    end
endmodule
